// ===== hdl/pswl_pkg.sv =====
// Package for the per-user sliding window limiter.
// Holds field widths, register indexes, defaults and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package pswl_pkg;

  localparam int USERS_DEF     = 1024;
  localparam int MAX_LIMIT_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam int USER_ID_W  = 10;
  localparam int REQ_TIME_W = 32;
  localparam int LIMIT_W    = 4;
  localparam int WINDOW_W   = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 1'b1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 4'd1;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 32'd1000;

  typedef struct packed {
    logic clear;
    logic capture;
    logic load;
    logic pop;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pop_ok;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/pswl_req_if.sv =====
// Request channel of the limiter: valid/ready handshake with user id and time.
// Depends on pswl_pkg.
`timescale 1ns / 1ps

interface pswl_req_if import pswl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [USER_ID_W-1:0]  user_id;
  logic [REQ_TIME_W-1:0] request_time;

  modport source (output valid, output user_id, output request_time, input ready);
  modport sink   (input valid, input user_id, input request_time, output ready);
endinterface

// ===== hdl/pswl_rsp_if.sv =====
// Response channel of the limiter: valid/ready handshake with the verdict.
// Depends on pswl_pkg.
`timescale 1ns / 1ps

interface pswl_rsp_if import pswl_pkg::*; ();
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

// ===== hdl/pswl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pswl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pswl_ctrl.sv =====
// Controller of the limiter: sequences clear pass, record load, trim loop and verdict.
// Depends on pswl_pkg for the command and status structs.
`timescale 1ns / 1ps

module pswl_ctrl import pswl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_POP,
    ST_DECIDE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_POP;
      end
      ST_POP: begin
        if (!status_i.pop_ok) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.clear   = (state_q == ST_CLEAR);
    cmd_o.capture = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.load    = (state_q == ST_LOAD);
    cmd_o.pop     = (state_q == ST_POP) && status_i.pop_ok;
    cmd_o.decide  = (state_q == ST_DECIDE) && status_i.out_free;
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

// ===== hdl/pswl_dp.sv =====
// Datapath of the limiter: per-user record RAM, timestamp ring RAM, trim compare,
// admit decision and the response register. Depends on pswl_pkg and pswl_ram.
`timescale 1ns / 1ps

module pswl_dp import pswl_pkg::*; #(
  parameter int USERS     = USERS_DEF,
  parameter int MAX_LIMIT = MAX_LIMIT_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [USER_ID_W-1:0]  user_id_i,
  input  logic [REQ_TIME_W-1:0] request_time_i,
  input  logic [LIMIT_W-1:0]    request_limit_i,
  input  logic [WINDOW_W-1:0]   window_length_i,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic                  rsp_accepted_o
);

  localparam int USER_AW     = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int HEAD_W      = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
  localparam int CNT_W       = $clog2(MAX_LIMIT + 1);
  localparam int META_W      = HEAD_W + CNT_W;
  localparam int STAMP_AW    = USER_AW + HEAD_W;
  localparam int STAMP_DEPTH = 2 ** STAMP_AW;

  logic [31:0]          user_ext;
  logic [USER_AW-1:0]   user_addr;
  logic                 user_oor;
  logic [63:0]          time_ext;
  logic [TIME_BITS-1:0] now;

  logic [USER_AW-1:0]   user_q;
  logic                 oor_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] cutoff_q, cutoff_d;
  logic                 expire_q, expire_d;
  logic [HEAD_W-1:0]    head_q;
  logic [CNT_W-1:0]     count_q;
  logic [USER_AW-1:0]   clr_addr_q;
  logic                 rsp_valid_q;
  logic                 rsp_acc_q;

  logic [META_W-1:0]    meta_rdata;
  logic [META_W-1:0]    meta_wdata;
  logic [USER_AW-1:0]   meta_waddr;
  logic                 meta_we;
  logic [HEAD_W-1:0]    head_rd;
  logic [CNT_W-1:0]     cnt_rd;
  logic [HEAD_W-1:0]    head_ld;
  logic [CNT_W-1:0]     cnt_ld;

  logic [TIME_BITS-1:0] stamp_rdata;
  logic [HEAD_W-1:0]    head_next;
  logic [HEAD_W-1:0]    head_sel;
  logic [CNT_W:0]       slot_sum;
  logic [CNT_W:0]       slot_wrap;
  logic [HEAD_W-1:0]    slot;
  logic                 admit;
  logic [CNT_W-1:0]     count_new;
  logic [63:0]          now_wide;
  logic [63:0]          win_wide;
  logic [63:0]          diff_wide;

  assign user_ext  = 32'(user_id_i);
  assign user_addr = user_ext[USER_AW-1:0];
  assign user_oor  = (user_ext >= 32'(USERS));
  assign time_ext  = 64'(request_time_i);
  assign now       = time_ext[TIME_BITS-1:0];

  assign head_rd = meta_rdata[META_W-1:CNT_W];
  assign cnt_rd  = meta_rdata[CNT_W-1:0];
  assign head_ld = (32'(head_rd) >= 32'(MAX_LIMIT)) ? '0 : head_rd;
  assign cnt_ld  = (32'(cnt_rd) > 32'(MAX_LIMIT)) ? CNT_W'(MAX_LIMIT) : cnt_rd;

  assign now_wide  = 64'(now_q);
  assign win_wide  = 64'(window_length_i);
  assign diff_wide = now_wide - win_wide;
  assign expire_d  = (now_wide >= win_wide);
  assign cutoff_d  = diff_wide[TIME_BITS-1:0];

  assign head_next = (32'(head_q) == 32'(MAX_LIMIT - 1)) ? '0 : head_q + HEAD_W'(1);
  assign head_sel  = cmd_i.load ? head_ld : (cmd_i.pop ? head_next : head_q);

  assign slot_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign slot_wrap = (32'(slot_sum) >= 32'(MAX_LIMIT)) ?
                     slot_sum - (CNT_W + 1)'(MAX_LIMIT) : slot_sum;
  assign slot      = slot_wrap[HEAD_W-1:0];

  assign admit = !oor_q && (8'(count_q) < 8'(request_limit_i)) &&
                 (8'(count_q) < 8'(MAX_LIMIT));
  assign count_new = admit ? count_q + CNT_W'(1) : count_q;

  assign meta_we    = cmd_i.clear || (cmd_i.decide && !oor_q);
  assign meta_waddr = cmd_i.clear ? clr_addr_q : user_q;
  assign meta_wdata = cmd_i.clear ? '0 : {head_q, count_new};

  pswl_ram #(
    .WIDTH (META_W),
    .DEPTH (USERS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (user_addr),
    .rdata_o (meta_rdata)
  );

  pswl_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.decide && admit),
    .waddr_i ({user_q, slot}),
    .wdata_i (now_q),
    .raddr_i ({user_q, head_sel}),
    .rdata_o (stamp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + USER_AW'(1);
      end
      if (cmd_i.decide) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      user_q <= user_addr;
      oor_q  <= user_oor;
      now_q  <= now;
    end
    if (cmd_i.load) begin
      head_q   <= head_ld;
      count_q  <= cnt_ld;
      expire_q <= expire_d;
      cutoff_q <= cutoff_d;
    end else if (cmd_i.pop) begin
      head_q  <= head_next;
      count_q <= count_q - CNT_W'(1);
    end
    if (cmd_i.decide) begin
      rsp_acc_q <= admit;
    end
  end

  assign status_o.clear_last = (clr_addr_q == USER_AW'(USERS - 1));
  assign status_o.pop_ok     = !oor_q && expire_q && (count_q != '0) &&
                               (stamp_rdata <= cutoff_q);
  assign status_o.out_free   = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_accepted_o = rsp_acc_q;

endmodule

// ===== hdl/per_user_sliding_window_limiter.sv =====
// Top level of the per-user sliding window limiter: configuration registers,
// controller, datapath. Depends on pswl_pkg, the channel interfaces, pswl_ctrl, pswl_dp.
//
// One request is handled at a time. After acceptance the user's record is loaded,
// the trim loop drops expired timestamps (0 to MAX_LIMIT) from the front of that
// user's ring, reading one timestamp from the ring RAM per cycle, and the verdict
// is written to the response register once that register is free. The next
// request can be taken in the cycle after the verdict is written, so no request is
// taken before the previous one has its verdict; a verdict waits in the response
// register while the next request is already being taken. After reset the per-user
// record RAM is swept to zero, one user per cycle, so no request is taken until the
// sweep is done; configuration writes are taken at any time.
`timescale 1ns / 1ps

module per_user_sliding_window_limiter import pswl_pkg::*; #(
  parameter int USERS     = USERS_DEF,
  parameter int MAX_LIMIT = MAX_LIMIT_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pswl_req_if.sink              req_i,
  pswl_rsp_if.source            rsp_o
);

  logic [LIMIT_W-1:0]  limit_q;
  logic [WINDOW_W-1:0] window_q;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      window_q <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_WINDOW: window_q <= cfg_wdata_i[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pswl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pswl_dp #(
    .USERS     (USERS),
    .MAX_LIMIT (MAX_LIMIT),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .user_id_i       (req_i.user_id),
    .request_time_i  (req_i.request_time),
    .request_limit_i (limit_q),
    .window_length_i (window_q),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_accepted_o  (rsp_o.accepted)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.capture, cmd.load, cmd.pop, cmd.decide}))
    else $error("more than one datapath command at once");

  a_load_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> cmd.load)
    else $error("record load did not follow a taken request");

  a_verdict_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.decide |=> rsp_o.valid)
    else $error("verdict not presented after decision");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !req_i.ready)
    else $error("request channel open during clear pass");

endmodule

// ===== bench/per_user_sliding_window_limiter_tb.sv =====
// Testbench for per_user_sliding_window_limiter: drives requests, predicts each verdict
// from a per-user timestamp ring model and checks every response in order.
// Depends on pswl_pkg, pswl_req_if, pswl_rsp_if and the limiter RTL.
`timescale 1ns / 1ps

module per_user_sliding_window_limiter_tb;
  import pswl_pkg::*;

  // Stall limit covers the reset sweep of the record RAM, the response hold, plus margin.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AFTER  = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [USER_ID_W-1:0]  user_id;
    logic [REQ_TIME_W-1:0] request_time;
  } request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_q    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_q  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_q  = '0;
  logic                  req_valid_q = 1'b0;
  logic [USER_ID_W-1:0]  req_user_q  = '0;
  logic [REQ_TIME_W-1:0] req_time_q  = '0;
  logic                  rsp_ready_q = 1'b0;

  pswl_req_if req ();
  pswl_rsp_if rsp ();

  assign req.valid        = req_valid_q;
  assign req.user_id      = req_user_q;
  assign req.request_time = req_time_q;
  assign rsp.ready        = rsp_ready_q;

  per_user_sliding_window_limiter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_q),
    .cfg_addr_i (cfg_addr_q),
    .cfg_wdata_i(cfg_data_q),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // Limiter state as the block should hold it.
  logic [REQ_TIME_W-1:0] stamp_log   [USERS_DEF][MAX_LIMIT_DEF];
  int unsigned           ring_first  [USERS_DEF];
  int unsigned           ring_fill   [USERS_DEF];
  logic [LIMIT_W-1:0]    limit_setting  = LIMIT_RST;
  logic [WINDOW_W-1:0]   window_setting = WINDOW_RST;

  request_t pending_requests[$];
  logic     expected_verdicts[$];

  int send_idle_pct   = 12;
  int rsp_stall_pct   = 76;
  int requests_taken  = 0;
  int verdicts_seen   = 0;
  int admitted_seen   = 0;
  int settings_used   = 0;
  int failures        = 0;
  int stall_cycles    = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic admit_request(logic [USER_ID_W-1:0] uid,
                                         logic [REQ_TIME_W-1:0] stamp);
    int unsigned           cap;
    int unsigned           first;
    int unsigned           fill;
    logic [REQ_TIME_W-1:0] cutoff;
    logic                  verdict;
    cap     = (limit_setting > MAX_LIMIT_DEF) ? MAX_LIMIT_DEF : limit_setting;
    first   = ring_first[uid];
    fill    = ring_fill[uid];
    verdict = 1'b0;
    if (stamp >= window_setting) begin
      cutoff = stamp - window_setting;
      while (fill > 0 && stamp_log[uid][first] <= cutoff) begin
        first = (first + 1) % MAX_LIMIT_DEF;
        fill--;
      end
    end
    if (fill < cap) begin
      stamp_log[uid][(first + fill) % MAX_LIMIT_DEF] = stamp;
      fill++;
      verdict = 1'b1;
    end
    ring_first[uid] = first;
    ring_fill[uid]  = fill;
    return verdict;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin
    request_t nxt;
    logic     verdict;
    if (rst_ni) begin
      if (req_valid_q && req.ready) begin
        verdict = admit_request(req_user_q, req_time_q);
        expected_verdicts.insert(expected_verdicts.size(), verdict);
        requests_taken++;
      end
      if (!req_valid_q || req.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt         = pending_requests.pop_front();
          req_valid_q <= 1'b1;
          req_user_q  <= nxt.user_id;
          req_time_q  <= nxt.request_time;
        end else begin
          req_valid_q <= 1'b0;
        end
      end
    end
  end

  // Response receiver and checker.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (rsp.valid && rsp_ready_q) begin
        verdicts_seen++;
        if (rsp.accepted === 1'b1) admitted_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("response with no request outstanding: accepted=%0b", rsp.accepted);
          failures++;
        end else begin
          want = expected_verdicts.pop_front();
          if (rsp.accepted !== want) begin
            $error("accepted: expected %0b, actual %0b", want, rsp.accepted);
            failures++;
          end
        end
      end
      if (!hold_done && requests_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready_q <= 1'b0;
      end else begin
        rsp_ready_q <= ($urandom_range(99) >= rsp_stall_pct);
      end
      if ((req_valid_q && req.ready) || (rsp.valid && rsp_ready_q)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("per_user_sliding_window_limiter_tb: FAIL");
    $finish;
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_q   <= 1'b1;
    cfg_addr_q <= idx;
    cfg_data_q <= val;
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
    if (idx == REG_LIMIT) limit_setting = val[LIMIT_W-1:0];
    else window_setting = val[WINDOW_W-1:0];
  endtask

  task automatic configure(logic [LIMIT_W-1:0] lim, logic [WINDOW_W-1:0] win);
    write_reg(REG_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_WINDOW, CFG_DATA_W'(win));
    settings_used++;
  endtask

  task automatic add_request(logic [USER_ID_W-1:0] uid, logic [REQ_TIME_W-1:0] stamp);
    request_t r;
    r.user_id      = uid;
    r.request_time = stamp;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || req_valid_q || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Mostly a few busy users on an advancing clock, some late stamps, some noise.
  task automatic queue_traffic(int n);
    logic [USER_ID_W-1:0]  busy [4];
    logic [REQ_TIME_W-1:0] stamp_now;
    logic [REQ_TIME_W-1:0] step_max;
    int                    pick;
    foreach (busy[k]) busy[k] = USER_ID_W'($urandom_range(USERS_DEF - 1));
    stamp_now = $urandom;
    step_max  = window_setting / 8 + 1;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        stamp_now += $urandom_range(0, step_max);
        add_request(busy[$urandom_range(3)], stamp_now);
      end else if (pick < 90) begin
        add_request(busy[$urandom_range(3)], stamp_now - $urandom_range(0, 2 * step_max));
      end else begin
        add_request(USER_ID_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic run_traffic(logic [LIMIT_W-1:0] lim, logic [WINDOW_W-1:0] win,
                             int idle_pct, int stall_pct, int n);
    configure(lim, win);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    queue_traffic(n);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit above capacity acts as eight; fill, overflow, full trim, late stamps.
    configure(4'd15, 32'd100);
    for (int t = 0; t < 8; t++) add_request('0, REQ_TIME_W'(t));
    add_request('0, 32'd8);
    add_request('0, 32'd200);
    add_request(10'd1023, 32'hFFFF_FFFF);
    add_request(10'd1023, 32'd0);
    add_request(10'd2, 32'd500);
    add_request(10'd2, 32'd10);
    add_request(10'd2, 32'd560);
    drain();

    // Zero window: equal stamps expire at once.
    configure(4'd2, 32'd0);
    add_request(10'd4, 32'd7);
    add_request(10'd4, 32'd7);
    add_request(10'd4, 32'd6);
    add_request(10'd4, 32'd6);
    drain();

    // Zero limit rejects everything.
    configure(4'd0, 32'hFFFF_FFFF);
    add_request(10'd6, 32'hFFFF_FFFF);
    drain();

    run_traffic(4'd4, 32'd1000, 12, 76, 400);
    run_traffic(4'd8, 32'd1, 76, 12, 300);
    run_traffic(4'd1, 32'hFFFF_FFFF, 0, 0, 150);
    run_traffic(4'd6, 32'd37, 0, 0, 280);

    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      failures++;
    end
    $display("run covered %0d requests (%0d admitted) over %0d limit/window settings,",
             verdicts_seen, admitted_seen, settings_used);
    $display("with a %0d-cycle response hold and three idling mixes", HOLD_CYCLES);
    if (failures == 0) begin
      $display("per_user_sliding_window_limiter_tb: PASS");
    end else begin
      $display("per_user_sliding_window_limiter_tb: FAIL");
    end
    $finish;
  end

endmodule
